### src/pn3_pkg.sv
// Package for the 3D improved noise block: widths, shared types, the
// gradient selection and the fixed-point lerp. No dependencies.
package pn3_pkg;

  localparam int PERM_SIZE = 256;
  localparam int IDX_W     = $clog2(PERM_SIZE);
  localparam int ENTRY_W   = 8;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int OUT_W     = 16;
  localparam int FADE_W    = FRAC_BITS + 2;
  localparam int VAL_W     = FRAC_BITS + 8;
  localparam int HASH_W    = 4;
  localparam int N_CORNER  = 8;
  localparam int N_PIPE    = 8;

  // Hash codes that steer the gradient selection.
  localparam logic [HASH_W-1:0] HASH_P_IS_Y = 4'd8;
  localparam logic [HASH_W-1:0] HASH_Q_NOT_Y = 4'd4;
  localparam logic [HASH_W-1:0] HASH_Q_X_LO = 4'd12;
  localparam logic [HASH_W-1:0] HASH_Q_X_HI = 4'd14;

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [ENTRY_W-1:0]          entry_t;
  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic signed [FADE_W-1:0]    fade_t;
  typedef logic signed [VAL_W-1:0]     val_t;
  typedef logic [HASH_W-1:0]           hash_t;
  typedef logic [N_CORNER-1:0][HASH_W-1:0] hash_vec_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    logic en;
    logic init;
    idx_t init_addr;
  } pipe_ctl_t;

  localparam fade_t FADE_ONE = FADE_W'(1 << FRAC_BITS);

  // Offset from a corner: the fraction, or the fraction minus one.
  function automatic fade_t corner_d(frac_t d, logic hi);
    fade_t base;
    base = $signed({2'b00, d});
    return hi ? base - FADE_ONE : base;
  endfunction

  function automatic val_t grad(hash_t h, fade_t gx, fade_t gy, fade_t gz);
    val_t p;
    val_t q;
    p = (h < HASH_P_IS_Y) ? val_t'(gx) : val_t'(gy);
    if (h < HASH_Q_NOT_Y) begin
      q = val_t'(gy);
    end else if (h == HASH_Q_X_LO || h == HASH_Q_X_HI) begin
      q = val_t'(gx);
    end else begin
      q = val_t'(gz);
    end
    if (h[0]) p = -p;
    if (h[1]) q = -q;
    return p + q;
  endfunction

  // a + floor(t * (b - a) / 2^FRAC_BITS)
  function automatic val_t lerp(fade_t t, val_t a, val_t b);
    logic signed [VAL_W:0]             diff;
    logic signed [VAL_W+FADE_W:0]      prod;
    diff = (VAL_W+1)'(b) - (VAL_W+1)'(a);
    prod = t * diff;
    return a + prod[FRAC_BITS +: VAL_W];
  endfunction

endpackage

### src/perlin_noise_3d.sv
// One item per cycle sustained while the output is not stalled.
// The whole pipeline advances together and holds while a result waits for out_ready.
// Reset: a pass over all 256 entries writes entry i = i into every permutation table copy;
// in_ready stays low during that pass. Load items give no result.
// Depends on pn3_pkg, pn3_hash, pn3_fade, pn3_blend, pn3_ram.
module perlin_noise_3d (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [7:0]                       in_table_index,
  input  logic [7:0]                       in_table_value,
  input  logic signed [pn3_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pn3_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [pn3_pkg::COORD_W-1:0] in_coord_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pn3_pkg::OUT_W-1:0]        out_noise_value
);

  localparam int F = pn3_pkg::FRAC_BITS;

  logic                     en;
  logic [pn3_pkg::IDX_W:0]  init_cnt_r;
  logic                     init_busy;
  pn3_pkg::pipe_ctl_t       ctl;

  logic                     vld1_r;
  pn3_pkg::op_t             op1_r;
  logic [pn3_pkg::N_PIPE:2] ev_r;
  logic                     out_valid_r;
  logic [pn3_pkg::OUT_W-1:0] out_noise_r, noise_nxt;

  pn3_pkg::idx_t   tidx1_r, cx1_r, cy1_r, cz1_r;
  pn3_pkg::entry_t tval1_r;
  pn3_pkg::frac_t  dx1_r, dy1_r, dz1_r;

  assign init_busy = !init_cnt_r[pn3_pkg::IDX_W];
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en && !init_busy;

  assign ctl.en        = en;
  assign ctl.init      = init_busy;
  assign ctl.init_addr = init_cnt_r[pn3_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      vld1_r      <= 1'b0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (init_busy) init_cnt_r <= init_cnt_r + 1'b1;
      if (en) begin
        vld1_r      <= in_valid && !init_busy;
        ev_r        <= {ev_r[pn3_pkg::N_PIPE-1:2], vld1_r && (op1_r == pn3_pkg::OP_EVAL)};
        out_valid_r <= ev_r[pn3_pkg::N_PIPE];
      end
    end
  end

  // The cell is the floor of the coordinate, wrapped to the table size.
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= pn3_pkg::op_t'(in_operation);
      tidx1_r <= pn3_pkg::idx_t'(in_table_index);
      tval1_r <= in_table_value;
      cx1_r   <= in_coord_x[F +: pn3_pkg::IDX_W];
      cy1_r   <= in_coord_y[F +: pn3_pkg::IDX_W];
      cz1_r   <= in_coord_z[F +: pn3_pkg::IDX_W];
      dx1_r   <= in_coord_x[F-1:0];
      dy1_r   <= in_coord_y[F-1:0];
      dz1_r   <= in_coord_z[F-1:0];
      out_noise_r <= noise_nxt;
    end
  end

  pn3_pkg::hash_vec_t hash;
  pn3_hash u_hash (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .ld_i(vld1_r && (op1_r == pn3_pkg::OP_LOAD)),
    .tidx_i(tidx1_r), .tval_i(tval1_r),
    .cx_i(cx1_r), .cy_i(cy1_r), .cz_i(cz1_r),
    .hash_o(hash)
  );

  pn3_pkg::frac_t dx4, dy4, dz4;
  pn3_pkg::fade_t u4, v4, w4;
  pn3_fade u_fade_x (.clk(clk), .en(en), .t_i(dx1_r), .t_o(dx4), .fade_o(u4));
  pn3_fade u_fade_y (.clk(clk), .en(en), .t_i(dy1_r), .t_o(dy4), .fade_o(v4));
  pn3_fade u_fade_z (.clk(clk), .en(en), .t_i(dz1_r), .t_o(dz4), .fade_o(w4));

  pn3_pkg::val_t res;
  pn3_blend u_blend (
    .clk(clk), .en(en), .hash_i(hash),
    .dx_i(dx4), .dy_i(dy4), .dz_i(dz4),
    .u_i(u4), .v_i(v4), .w_i(w4),
    .res_o(res)
  );

  // (res + 1) / 2, floored, clamped to the 16-bit output range.
  logic signed [pn3_pkg::VAL_W:0] shifted;
  logic [pn3_pkg::VAL_W-1:0]      half;
  assign shifted = (pn3_pkg::VAL_W+1)'(res) + (pn3_pkg::VAL_W+1)'(1 << F);
  assign half    = shifted[pn3_pkg::VAL_W:1];

  always_comb begin
    if (shifted < 0) begin
      noise_nxt = '0;
    end else if (half > pn3_pkg::VAL_W'(16'hFFFF)) begin
      noise_nxt = '1;
    end else begin
      noise_nxt = half[pn3_pkg::OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule

### src/pn3_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module pn3_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr0,
  input  logic [$clog2(D)-1:0] raddr1,
  output logic [W-1:0]         rdata0,
  output logic [W-1:0]         rdata1
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### src/pn3_hash.sv
// Three-stage corner hash: chained permutation lookups in seven table copies.
// Depends on pn3_pkg and pn3_ram.
module pn3_hash (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pn3_pkg::pipe_ctl_t   ctl,
  input  logic                 ld_i,
  input  pn3_pkg::idx_t        tidx_i,
  input  pn3_pkg::entry_t      tval_i,
  input  pn3_pkg::idx_t        cx_i,
  input  pn3_pkg::idx_t        cy_i,
  input  pn3_pkg::idx_t        cz_i,
  output pn3_pkg::hash_vec_t   hash_o
);

  logic            ld2_r, ld3_r;
  pn3_pkg::idx_t   tidx2_r, tidx3_r, cy2_r, cz2_r, cz3_r;
  pn3_pkg::entry_t tval2_r, tval3_r;

  // Load items pass down so that every table copy sees writes in item order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld2_r <= 1'b0;
      ld3_r <= 1'b0;
    end else if (ctl.en) begin
      ld2_r <= ld_i;
      ld3_r <= ld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      tidx2_r <= tidx_i;
      tidx3_r <= tidx2_r;
      tval2_r <= tval_i;
      tval3_r <= tval2_r;
      cy2_r   <= cy_i;
      cz2_r   <= cz_i;
      cz3_r   <= cz2_r;
    end
  end

  logic            we1, we2, we3;
  pn3_pkg::idx_t   wa1, wa2, wa3;
  pn3_pkg::entry_t wd1, wd2, wd3, init_val;

  assign init_val = pn3_pkg::entry_t'(ctl.init_addr);
  assign we1 = ctl.init | (ctl.en & ld_i);
  assign we2 = ctl.init | (ctl.en & ld2_r);
  assign we3 = ctl.init | (ctl.en & ld3_r);
  assign wa1 = ctl.init ? ctl.init_addr : tidx_i;
  assign wa2 = ctl.init ? ctl.init_addr : tidx2_r;
  assign wa3 = ctl.init ? ctl.init_addr : tidx3_r;
  assign wd1 = ctl.init ? init_val : tval_i;
  assign wd2 = ctl.init ? init_val : tval2_r;
  assign wd3 = ctl.init ? init_val : tval3_r;

  // First lookup: cell x and its neighbor.
  pn3_pkg::entry_t p1_lo, p1_hi;
  pn3_ram #(.W(pn3_pkg::ENTRY_W), .D(pn3_pkg::PERM_SIZE)) u_ram_x (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .re(ctl.en),
    .raddr0(cx_i), .raddr1(cx_i + pn3_pkg::idx_t'(1)),
    .rdata0(p1_lo), .rdata1(p1_hi)
  );

  pn3_pkg::idx_t a_idx, b_idx;
  assign a_idx = pn3_pkg::idx_t'(p1_lo) + cy2_r;
  assign b_idx = pn3_pkg::idx_t'(p1_hi) + cy2_r;

  pn3_pkg::entry_t qa0, qa1, qb0, qb1;
  pn3_ram #(.W(pn3_pkg::ENTRY_W), .D(pn3_pkg::PERM_SIZE)) u_ram_a (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wd2), .re(ctl.en),
    .raddr0(a_idx), .raddr1(a_idx + pn3_pkg::idx_t'(1)),
    .rdata0(qa0), .rdata1(qa1)
  );
  pn3_ram #(.W(pn3_pkg::ENTRY_W), .D(pn3_pkg::PERM_SIZE)) u_ram_b (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wd2), .re(ctl.en),
    .raddr0(b_idx), .raddr1(b_idx + pn3_pkg::idx_t'(1)),
    .rdata0(qb0), .rdata1(qb1)
  );

  // Bases ordered as x + 2*y: aa, ba, ab, bb.
  pn3_pkg::idx_t base [4];
  assign base[0] = pn3_pkg::idx_t'(qa0) + cz3_r;
  assign base[1] = pn3_pkg::idx_t'(qb0) + cz3_r;
  assign base[2] = pn3_pkg::idx_t'(qa1) + cz3_r;
  assign base[3] = pn3_pkg::idx_t'(qb1) + cz3_r;

  for (genvar r = 0; r < 4; r++) begin : g_corner
    pn3_pkg::entry_t h_lo, h_hi;
    pn3_ram #(.W(pn3_pkg::ENTRY_W), .D(pn3_pkg::PERM_SIZE)) u_ram_c (
      .clk(clk), .we(we3), .waddr(wa3), .wdata(wd3), .re(ctl.en),
      .raddr0(base[r]), .raddr1(base[r] + pn3_pkg::idx_t'(1)),
      .rdata0(h_lo), .rdata1(h_hi)
    );
    assign hash_o[r]     = h_lo[pn3_pkg::HASH_W-1:0];
    assign hash_o[r + 4] = h_hi[pn3_pkg::HASH_W-1:0];
  end

endmodule

### src/pn3_fade.sv
// Three-stage fade curve 6t^5 - 15t^4 + 10t^3 on one fraction.
// Depends on pn3_pkg.
module pn3_fade (
  input  logic                clk,
  input  logic                en,
  input  pn3_pkg::frac_t      t_i,
  output pn3_pkg::frac_t      t_o,
  output pn3_pkg::fade_t      fade_o
);

  localparam int F   = pn3_pkg::FRAC_BITS;
  localparam int K_W = F + 6;
  localparam int M_W = F + 1 + K_W;

  logic [K_W-1:0]          k;
  logic signed [M_W-1:0]   m;
  logic [2*F-1:0]          sq, cube;
  logic signed [M_W-1:0]   fp;

  pn3_pkg::frac_t          ta_r, tb_r, tc_r, t2_r, t3_r;
  logic signed [K_W-1:0]   m1_r, inner_r;
  pn3_pkg::fade_t          fade_r;

  assign k  = K_W'(t_i) * K_W'(6) - K_W'(15 << F);
  assign m  = $signed({1'b0, t_i}) * $signed(k);
  assign sq = t_i * t_i;
  assign cube = t2_r * ta_r;
  assign fp = $signed({1'b0, t3_r}) * inner_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r    <= t_i;
      t2_r    <= sq[2*F-1:F];
      m1_r    <= m[F +: K_W];
      tb_r    <= ta_r;
      t3_r    <= cube[2*F-1:F];
      inner_r <= m1_r + $signed(K_W'(10 << F));
      tc_r    <= tb_r;
      fade_r  <= fp[F +: pn3_pkg::FADE_W];
    end
  end

  assign t_o    = tc_r;
  assign fade_o = fade_r;

endmodule

### src/pn3_blend.sv
// Four-stage gradient and trilinear blend: gradients, x, y and z lerps.
// Depends on pn3_pkg.
module pn3_blend (
  input  logic                clk,
  input  logic                en,
  input  pn3_pkg::hash_vec_t  hash_i,
  input  pn3_pkg::frac_t      dx_i,
  input  pn3_pkg::frac_t      dy_i,
  input  pn3_pkg::frac_t      dz_i,
  input  pn3_pkg::fade_t      u_i,
  input  pn3_pkg::fade_t      v_i,
  input  pn3_pkg::fade_t      w_i,
  output pn3_pkg::val_t       res_o
);

  pn3_pkg::val_t  g_nxt [8];
  pn3_pkg::val_t  g_r [8];
  pn3_pkg::val_t  xl_r [4];
  pn3_pkg::val_t  yl_r [2];
  pn3_pkg::val_t  res_r;
  pn3_pkg::fade_t u5_r, v5_r, v6_r, w5_r, w6_r, w7_r;

  // Corner index is z*4 + y*2 + x.
  for (genvar c = 0; c < 8; c++) begin : g_grad
    assign g_nxt[c] = pn3_pkg::grad(hash_i[c],
                                    pn3_pkg::corner_d(dx_i, c[0]),
                                    pn3_pkg::corner_d(dy_i, c[1]),
                                    pn3_pkg::corner_d(dz_i, c[2]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) g_r[c] <= g_nxt[c];
      u5_r <= u_i;
      v5_r <= v_i;
      w5_r <= w_i;
      for (int j = 0; j < 4; j++) xl_r[j] <= pn3_pkg::lerp(u5_r, g_r[2*j], g_r[2*j+1]);
      v6_r <= v5_r;
      w6_r <= w5_r;
      for (int k = 0; k < 2; k++) yl_r[k] <= pn3_pkg::lerp(v6_r, xl_r[2*k], xl_r[2*k+1]);
      w7_r <= w6_r;
      res_r <= pn3_pkg::lerp(w7_r, yl_r[0], yl_r[1]);
    end
  end

  assign res_o = res_r;

endmodule

### tb/perlin_noise_3d_test.sv
// Self-checking bench for perlin_noise_3d: table loads and noise evaluations
// are driven over valid/ready and each result is checked against a local predictor.
// Depends on pn3_pkg and the perlin_noise_3d RTL.
module perlin_noise_3d_test;

  class noise_board;
    logic [7:0] perm [pn3_pkg::PERM_SIZE];
    logic [15:0] pending [$];
    int errors;

    function void clear_table();
      for (int i = 0; i < pn3_pkg::PERM_SIZE; i++) perm[i] = i[7:0];
      errors = 0;
    endfunction

    function longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> pn3_pkg::FRAC_BITS;
    endfunction

    function longint wrapi(longint v);
      longint m;
      m = v % pn3_pkg::PERM_SIZE;
      if (m < 0) m += pn3_pkg::PERM_SIZE;
      return m;
    endfunction

    function longint lk(longint i);
      return perm[wrapi(i)];
    endfunction

    function longint fade(longint t);
      longint t3;
      t3 = fmul(fmul(t, t), t);
      return fmul(t3, fmul(t, 6 * t - 15 * (1 << pn3_pkg::FRAC_BITS))
                      + 10 * (1 << pn3_pkg::FRAC_BITS));
    endfunction

    function longint mix(longint t, longint a, longint b);
      return a + fmul(t, b - a);
    endfunction

    function longint gsum(longint hv, longint gx, longint gy, longint gz);
      logic [3:0] h;
      longint p;
      longint q;
      h = hv[3:0];
      p = (h < pn3_pkg::HASH_P_IS_Y) ? gx : gy;
      q = (h < pn3_pkg::HASH_Q_NOT_Y) ? gy :
          ((h == pn3_pkg::HASH_Q_X_LO || h == pn3_pkg::HASH_Q_X_HI) ? gx : gz);
      return (h[0] ? -p : p) + (h[1] ? -q : q);
    endfunction

    // Notes an accepted item: loads update the table, evaluations queue a result.
    function void note_item(pn3_pkg::op_t op, logic [7:0] idx, logic [7:0] val,
                            logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
      longint one, cx, cy, cz, dx, dy, dz, u, v, w, a, aa, ab, b, ba, bb;
      longint x1, x2, y1, y2, r;
      one = 1 << pn3_pkg::FRAC_BITS;
      if (op == pn3_pkg::OP_LOAD) begin
        perm[wrapi(idx)] = val;
        return;
      end
      dx = x & (one - 1); cx = wrapi((longint'(x) - dx) / one);
      dy = y & (one - 1); cy = wrapi((longint'(y) - dy) / one);
      dz = z & (one - 1); cz = wrapi((longint'(z) - dz) / one);
      u = fade(dx); v = fade(dy); w = fade(dz);
      a = wrapi(lk(cx) + cy); aa = wrapi(lk(a) + cz); ab = wrapi(lk(a + 1) + cz);
      b = wrapi(lk(cx + 1) + cy); ba = wrapi(lk(b) + cz); bb = wrapi(lk(b + 1) + cz);
      x1 = mix(u, gsum(lk(aa), dx, dy, dz), gsum(lk(ba), dx - one, dy, dz));
      x2 = mix(u, gsum(lk(ab), dx, dy - one, dz), gsum(lk(bb), dx - one, dy - one, dz));
      y1 = mix(v, x1, x2);
      x1 = mix(u, gsum(lk(aa + 1), dx, dy, dz - one),
               gsum(lk(ba + 1), dx - one, dy, dz - one));
      x2 = mix(u, gsum(lk(ab + 1), dx, dy - one, dz - one),
               gsum(lk(bb + 1), dx - one, dy - one, dz - one));
      y2 = mix(v, x1, x2);
      r = mix(w, y1, y2) + one;
      if (r < 0) r = 0;
      r = r >>> 1;
      if (r > 65535) r = 65535;
      pending.push_back(r[15:0]);
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: noise_value expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_operation = 0;
  logic [7:0] in_table_index = 0;
  logic [7:0] in_table_value = 0;
  logic signed [31:0] in_coord_x = 0;
  logic signed [31:0] in_coord_y = 0;
  logic signed [31:0] in_coord_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_noise_value;

  noise_board board = new();
  bit calm = 0;
  bit hold_out = 0;

  perlin_noise_3d DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_item(pn3_pkg::op_t'(in_operation), in_table_index, in_table_value,
                      in_coord_x, in_coord_y, in_coord_z);
    if (rst_n && out_valid && out_ready) board.check_result(out_noise_value);
  end

  // Receiver: random stall bursts, a long hold when asked, none near the end.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 0;
        repeat (60) @(negedge clk);
        hold_out = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Valid stays high after an item is taken; the next item, an idle burst or a
  // drain replaces it at the following falling edge.
  task automatic send(pn3_pkg::op_t op, logic [7:0] idx, logic [7:0] val,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_table_index <= idx;
    in_table_value <= val;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send(pn3_pkg::OP_EVAL, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  task automatic wait_drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 20 << 16);
      2: return -$urandom_range(0, 20 << 16);
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  initial begin
    board.clear_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Directed: extremes of coordinates, lattice points, table wrap sums.
    eval_at(0, 0, 0);
    eval_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    eval_at(32'h80000000, 32'h80000000, 32'h80000000);
    eval_at(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    eval_at(32'h0000FFFF, 32'h00008000, 32'hFFFF0000);
    eval_at(32'h00FF8000, 32'hFF007FFF, 32'h00010001);
    send(pn3_pkg::OP_LOAD, 8'hFF, 8'hFF, 0, 0, 0);
    send(pn3_pkg::OP_LOAD, 8'h00, 8'hFF, 0, 0, 0);
    send(pn3_pkg::OP_LOAD, 8'h01, 8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(pn3_pkg::OP_LOAD, 8'hAA, 8'h55, 0, 0, 0);
    eval_at(32'h00FF4000, 32'h00FFC000, 32'h00FF2000);
    eval_at(0, 32'h0000C000, 32'h80004000);
    for (int h = 0; h < 16; h++) send(pn3_pkg::OP_LOAD, h[7:0], {4'h0, h[3:0]}, 0, 0, 0);
    eval_at(32'h00003000, 32'h00009000, 32'h0000E000);
    // Sender pauses until the block is empty.
    wait_drain();
    // Receiver holds off while the sender keeps offering items.
    hold_out = 1;
    for (int i = 0; i < 40; i++) eval_at(rand_coord(), rand_coord(), rand_coord());
    for (int i = 0; i < 1000; i++) begin
      if (i == 850) calm = 1;
      if ($urandom_range(0, 9) < 2)
        send(pn3_pkg::OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
      else
        eval_at(rand_coord(), rand_coord(), rand_coord());
    end
    wait_drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
